// ----- hdl/tsb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsb_pkg
// shared types and codes for the timer slot bank: action and result kinds,
// the slot state word and the beats passed between the control and output
// stages
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int RES_CAP       = 16;
    localparam int CNT_W         = $clog2(RES_CAP + 1);
    localparam int SLOT_W        = 4;
    localparam int TIME_W        = 32;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_CREATE    = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_EXPIRY    = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] slot;
        logic              run;
        logic              auto_reload;
        logic [TIME_W-1:0] timeout;
    } in_item_t;

    typedef struct packed {
        logic              running;
        logic              reload_mode;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] count;
    } slot_word_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic              ok;
        logic              last;
    } res_beat_t;

endpackage

// ----- hdl/timer_slot_bank_core.sv -----
// ----------------------------------------------------------------------------
// timer_slot_bank_core
// bank of tick-driven timers: create, delete, set and tick requests in,
// create answers, done beats, expiry events and idle-tick beats out
//
//   channel  dir  tdata                                   tuser      tlast
//   s_axis   in   slot, run, auto_reload, timeout         action     -
//   m_axis   out  result_slot, ok                         kind       last
//
// delete and set go straight to their answer, create scans the slots for a free
// one and tick sweeps every slot; each waits while the output register stays full.
// the tick sweep is paced by the state memory's single read port, one slot per
// cycle with read-modify-write unless stalled; expiry events leave while the sweep runs.
// reset clears the slot allocation flags at once; no clearing pass.
// a full output register stalls the sweep on the slot being visited.
// ----------------------------------------------------------------------------
module timer_slot_bank_core #(
    parameter int SLOTS = tsb_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // slot[3:0], run[4], auto_reload[5], timeout[37:6], pad
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // result_slot[3:0], ok[4], pad
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tsb_pkg::in_item_t   item;
    tsb_pkg::slot_word_t wr_data;
    tsb_pkg::slot_word_t rd_data;
    tsb_pkg::res_beat_t  push;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic                out_free;

    assign item = '{action: s_axis_tuser, slot: s_axis_tdata[3:0], run: s_axis_tdata[4],
                    auto_reload: s_axis_tdata[5], timeout: s_axis_tdata[37:6]};

    tsb_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .item     (item),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .out_free (out_free),
        .push     (push)
    );

    tsb_state_ram #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsb_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // one request at a time: ready drops after a beat is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a request is in progress");

    // only expiry events may be followed by more beats of the same request
    a_non_last_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == tsb_pkg::KIND_EXPIRY)
        else $error("non-final beat that is not an expiry");

    // a failed create reports slot zero
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == tsb_pkg::KIND_CREATE && !m_axis_tdata[4]
        |-> m_axis_tdata[3:0] == 4'd0)
        else $error("failed create with nonzero slot");

    // a push never lands on a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("result pushed into a full output register");

endmodule

// ----- hdl/tsb_state_ram.sv -----
// ----------------------------------------------------------------------------
// tsb_state_ram
// per-slot state memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tsb_state_ram #(
    parameter int SLOTS = tsb_pkg::SLOTS_DEFAULT,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  tsb_pkg::slot_word_t wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output tsb_pkg::slot_word_t rd_data
);

    tsb_pkg::slot_word_t slot_mem_reg [SLOTS];
    tsb_pkg::slot_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/tsb_out_stage.sv -----
// ----------------------------------------------------------------------------
// tsb_out_stage
// result output register: takes one beat when free and holds it until the
// downstream side takes it
// ----------------------------------------------------------------------------
module tsb_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  tsb_pkg::res_beat_t push,
    output logic               out_free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // result_slot[3:0], ok[4], zero pad
    output logic [1:0]         m_axis_tuser,   // kind[1:0]
    output logic               m_axis_tlast
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [1:0]                 kind_reg;
    logic [tsb_pkg::SLOT_W-1:0] slot_reg;
    logic                       ok_reg;
    logic                       last_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            kind_reg <= push.kind;
            slot_reg <= push.slot;
            ok_reg   <= push.ok;
            last_reg <= push.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000, ok_reg, slot_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ----- hdl/tsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsb_ctrl
// sequencer for the timer slot bank: allocation scan, delete and set,
// and the tick sweep that reads each slot and decrements and writes back each allocated, running slot
// ----------------------------------------------------------------------------
module tsb_ctrl #(
    parameter int SLOTS = tsb_pkg::SLOTS_DEFAULT,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsb_pkg::in_item_t   item,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output tsb_pkg::slot_word_t wr_data,
    output logic [IDX_W-1:0]    rd_addr,
    input  tsb_pkg::slot_word_t rd_data,
    input  logic                out_free,
    output tsb_pkg::res_beat_t  push
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CREATE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [SLOTS-1:0]            in_use_reg, in_use_next;
    logic                        held_valid_reg, held_valid_next;
    logic [tsb_pkg::SLOT_W-1:0]  held_slot_reg, held_slot_next;
    logic [tsb_pkg::CNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic [1:0]                  resp_kind_reg, resp_kind_next;
    logic [tsb_pkg::SLOT_W-1:0]  resp_slot_reg, resp_slot_next;
    logic                        resp_ok_reg, resp_ok_next;
    logic                        run_reg, run_next;
    logic                        reload_reg, reload_next;
    logic [tsb_pkg::TIME_W-1:0]  timeout_reg, timeout_next;

    logic [IDX_W-1:0]            idx_inc;
    logic [IDX_W-1:0]            item_idx;
    logic                        item_in_range;
    logic                        hit;
    logic [tsb_pkg::TIME_W-1:0]  count_dec;
    logic                        expire;
    logic                        report;
    logic                        need_push;
    logic                        stall;

    assign idx_inc       = idx_reg + IDX_W'(1);
    assign item_idx      = IDX_W'(item.slot);
    assign item_in_range = {3'b000, item.slot} < 7'(SLOTS);
    assign hit           = in_use_reg[idx_reg] && rd_data.running;
    assign count_dec     = rd_data.count - 32'd1;
    assign expire        = hit && (count_dec == '0);
    assign report        = expire && (rep_cnt_reg < tsb_pkg::CNT_W'(tsb_pkg::RES_CAP));
    assign need_push     = report && held_valid_reg;
    assign stall         = need_push && !out_free;
    assign in_ready      = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_use_next     = in_use_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        rep_cnt_next    = rep_cnt_reg;
        resp_kind_next  = resp_kind_reg;
        resp_slot_next  = resp_slot_reg;
        resp_ok_next    = resp_ok_reg;
        run_next        = run_reg;
        reload_next     = reload_reg;
        timeout_next    = timeout_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;
        rd_addr         = '0;
        push            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (item.action)
                        tsb_pkg::ACT_CREATE:
                        begin
                            run_next     = item.run;
                            reload_next  = item.auto_reload;
                            timeout_next = item.timeout;
                            idx_next     = '0;
                            state_next   = ST_CREATE;
                        end
                        tsb_pkg::ACT_DELETE:
                        begin
                            if (item_in_range)
                            begin
                                in_use_next[item_idx] = 1'b0;
                            end
                            resp_kind_next = tsb_pkg::KIND_DONE;
                            resp_slot_next = item.slot;
                            resp_ok_next   = 1'b1;
                            state_next     = ST_RESP;
                        end
                        tsb_pkg::ACT_SET:
                        begin
                            if (item_in_range)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = item_idx;
                                wr_data = '{running: item.run, reload_mode: item.auto_reload,
                                            period: item.timeout, count: item.timeout};
                            end
                            resp_kind_next = tsb_pkg::KIND_DONE;
                            resp_slot_next = item.slot;
                            resp_ok_next   = 1'b1;
                            state_next     = ST_RESP;
                        end
                        default:
                        begin
                            idx_next        = '0;
                            held_valid_next = 1'b0;
                            rep_cnt_next    = '0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (!in_use_reg[idx_reg])
                begin
                    wr_en                = 1'b1;
                    wr_addr              = idx_reg;
                    wr_data              = '{running: run_reg, reload_mode: reload_reg,
                                             period: timeout_reg, count: timeout_reg};
                    in_use_next[idx_reg] = 1'b1;
                    resp_kind_next       = tsb_pkg::KIND_CREATE;
                    resp_slot_next       = tsb_pkg::SLOT_W'(idx_reg);
                    resp_ok_next         = 1'b1;
                    state_next           = ST_RESP;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    resp_kind_next = tsb_pkg::KIND_CREATE;
                    resp_slot_next = '0;
                    resp_ok_next   = 1'b0;
                    state_next     = ST_RESP;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_SCAN:
            begin
                if (need_push && out_free)
                begin
                    push = '{valid: 1'b1, kind: tsb_pkg::KIND_EXPIRY, slot: held_slot_reg,
                             ok: 1'b1, last: 1'b0};
                end
                if (stall)
                begin
                    // re-read the same slot so the read data stays put
                    rd_addr = idx_reg;
                end
                else
                begin
                    if (hit)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = '{running: rd_data.running,
                                    reload_mode: rd_data.reload_mode,
                                    period: rd_data.period,
                                    count: (expire && rd_data.reload_mode) ?
                                           rd_data.period : count_dec};
                    end
                    if (expire && !rd_data.reload_mode)
                    begin
                        in_use_next[idx_reg] = 1'b0;
                    end
                    if (report)
                    begin
                        held_valid_next = 1'b1;
                        held_slot_next  = tsb_pkg::SLOT_W'(idx_reg);
                        rep_cnt_next    = rep_cnt_reg + tsb_pkg::CNT_W'(1);
                    end
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (held_valid_reg)
                    begin
                        push = '{valid: 1'b1, kind: tsb_pkg::KIND_EXPIRY,
                                 slot: held_slot_reg, ok: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        push = '{valid: 1'b1, kind: tsb_pkg::KIND_IDLE_TICK,
                                 slot: '0, ok: 1'b1, last: 1'b1};
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    push = '{valid: 1'b1, kind: resp_kind_reg, slot: resp_slot_reg,
                             ok: resp_ok_reg, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            in_use_reg     <= '0;
            held_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            in_use_reg     <= in_use_next;
            held_valid_reg <= held_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_slot_reg <= held_slot_next;
        resp_kind_reg <= resp_kind_next;
        resp_slot_reg <= resp_slot_next;
        resp_ok_reg   <= resp_ok_next;
        run_reg       <= run_next;
        reload_reg    <= reload_next;
        timeout_reg   <= timeout_next;
    end

endmodule
